### src/fsd_pkg.sv
// Shared types, constants and helpers for the Floyd-Steinberg dither block.
// No dependencies; imported by every module under src.
`default_nettype none

package fsd_pkg;

    localparam int CFG_W_BITS = 12;
    localparam int CFG_H_BITS = 13;

    localparam logic [CFG_W_BITS-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_H_BITS-1:0] RESET_HEIGHT = 13'd480;

    // register index, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [7:0] THRESHOLD = 8'd128;
    localparam logic [7:0] PIX_MAX   = 8'd255;
    localparam logic [7:0] PIX_MIN   = 8'd0;

    localparam logic signed [10:0] WGT_RIGHT = 11'sd7;
    localparam logic signed [10:0] WGT_BL    = 11'sd3;
    localparam logic signed [10:0] WGT_BELOW = 11'sd5;
    localparam logic signed [10:0] DIV_BIAS  = 11'sd15;  // 16 - 1

    // diffused error, magnitude stays below 70
    typedef logic signed [7:0] t_err;

    typedef struct packed {
        logic [CFG_W_BITS-1:0] image_width;
        logic [CFG_H_BITS-1:0] image_height;
    } t_cfg;

    typedef struct packed {
        logic [7:0] quant;       // 0 or 255
        t_err       left_wr;     // finished next-row entry for column x-1
        t_err       pend_left;   // next value of the pending left error
        t_err       pend_center; // next value of the pending center error
        t_err       right;       // error carried to the right neighbor
    } t_diff_out;

    // signed divide by 16, truncating toward zero
    function automatic t_err div16(input logic signed [10:0] v);
        logic signed [10:0] adj;
        adj = v + (v[10] ? DIV_BIAS : 11'sd0);
        return t_err'(adj >>> 4);
    endfunction

endpackage

`default_nettype wire

### src/floyd_steinberg_dither.sv
// Top level of the Floyd-Steinberg error diffusion dither.
// Depends on fsd_pkg, fsd_apb_regs, fsd_line_buf and fsd_diffuse.
//
//   port group   direction  handshake             word
//   pixel in     in         i_valid / o_ready     i_gray_pixel
//   pixel out    out        o_valid / i_ready     o_dithered_pixel, o_end_of_row,
//                                                 o_end_of_frame
//   config       in         APB psel/penable      image_width (0x0), image_height (0x4)
//
// One pixel per clock once the buffer is cleared and while i_ready is high; o_valid
// rises when the pixel moves from the input register into the output register. The
// line buffer read is issued at accept, the arithmetic runs from the input register
// into the output register. Writes into the line buffer that land in the same cycle
// as a read are forwarded. After reset the buffer is zeroed one entry per cycle, with
// o_ready low until all MAX_WIDTH entries are clear. Reset is synchronous; a stalled
// output holds its word while one more pixel waits in the input register.
`default_nettype none

module floyd_steinberg_dither
    import fsd_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_gray_pixel,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_dithered_pixel,
    output logic             o_end_of_row,
    output logic             o_end_of_frame,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

    t_cfg cfg;

    // position of the next pixel to be accepted
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic [WID_W-1:0] eff_w;
    logic [HGT_W-1:0] eff_h;
    logic             in_last_col;
    logic             in_last_row;
    logic             accept;
    logic             a_adv;
    logic             out_free;

    // clearing pass over the line buffer after reset
    logic             r_clr_busy;
    logic [COL_W-1:0] r_clr_addr;

    // input register
    logic             r_a_valid;
    logic [7:0]       r_a_pix;
    logic [COL_W-1:0] r_a_col;
    logic             r_a_first_row;
    logic             r_a_last_col;
    logic             r_a_last_row;
    logic             r_a_byp_hit;
    t_err             r_a_byp_data;

    // running errors
    t_err r_right;
    t_err r_pend_left;
    t_err r_pend_center;

    // last-column entry waits here for a free write slot
    logic             r_defer_valid;
    logic [COL_W-1:0] r_defer_addr;
    t_err             r_defer_data;
    logic             n_defer_valid;
    logic [COL_W-1:0] n_defer_addr;
    t_err             n_defer_data;

    logic             direct_wr;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    t_err             wr_data;
    t_err             mem_q;
    t_err             below;
    t_diff_out        res;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_pix;
    logic       r_out_eor;
    logic       r_out_eof;

    fsd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // effective dimensions: zero means one, saturate at the maximum
    always_comb begin
        if (cfg.image_width == '0) begin
            eff_w = WID_W'(1);
        end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else begin
            eff_w = WID_W'(cfg.image_width);
        end
        if (cfg.image_height == '0) begin
            eff_h = HGT_W'(1);
        end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
            eff_h = HGT_W'(MAX_HEIGHT);
        end else begin
            eff_h = HGT_W'(cfg.image_height);
        end
    end

    assign in_last_col = (WID_W'(r_col) + WID_W'(1)) >= eff_w;
    assign in_last_row = (HGT_W'(r_row) + HGT_W'(1)) >= eff_h;

    assign out_free = !r_out_valid || i_ready;
    assign a_adv    = r_a_valid && out_free;
    assign o_ready  = !r_clr_busy && (!r_a_valid || out_free);
    assign accept   = i_valid && o_ready;

    // line buffer write arbitration
    assign direct_wr = a_adv && !r_a_last_row && (r_a_col != '0);

    always_comb begin
        n_defer_valid = r_defer_valid && direct_wr;
        n_defer_addr  = r_defer_addr;
        n_defer_data  = r_defer_data;
        if (a_adv && !r_a_last_row && r_a_last_col) begin
            n_defer_valid = 1'b1;
            n_defer_addr  = r_a_col;
            n_defer_data  = res.pend_left;
        end
        wr_en   = r_clr_busy || direct_wr || r_defer_valid;
        if (r_clr_busy) begin
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_addr = direct_wr ? (r_a_col - COL_W'(1)) : r_defer_addr;
            wr_data = direct_wr ? res.left_wr : r_defer_data;
        end
    end

    fsd_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (mem_q)
    );

    always_comb begin
        if (r_a_first_row) begin
            below = '0;
        end else if (r_a_byp_hit) begin
            below = r_a_byp_data;
        end else begin
            below = mem_q;
        end
    end

    fsd_diffuse u_diff (
        .i_pix         (r_a_pix),
        .i_below       (below),
        .i_right       (r_right),
        .i_pend_left   (r_pend_left),
        .i_pend_center (r_pend_center),
        .i_last_col    (r_a_last_col),
        .o_res         (res)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_row         <= '0;
            r_a_valid     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_defer_valid <= 1'b0;
            r_right       <= '0;
            r_pend_left   <= '0;
            r_pend_center <= '0;
            r_clr_busy    <= 1'b1;
            r_clr_addr    <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + COL_W'(1);
                if (r_clr_addr == COL_W'(MAX_WIDTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_defer_valid <= n_defer_valid;
            if (accept) begin
                if (in_last_col) begin
                    r_col <= '0;
                    r_row <= in_last_row ? '0 : (r_row + ROW_W'(1));
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (a_adv) begin
                if (r_a_last_col) begin
                    r_right       <= '0;
                    r_pend_left   <= '0;
                    r_pend_center <= '0;
                end else begin
                    r_right <= res.right;
                    if (!r_a_last_row) begin
                        r_pend_left   <= res.pend_left;
                        r_pend_center <= res.pend_center;
                    end
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_defer_addr <= n_defer_addr;
        r_defer_data <= n_defer_data;
        if (accept) begin
            r_a_pix       <= i_gray_pixel;
            r_a_col       <= r_col;
            r_a_first_row <= (r_row == '0);
            r_a_last_col  <= in_last_col;
            r_a_last_row  <= in_last_row;
            // forward the newest value: a fresh last-column entry beats an older
            // one that lands in the buffer at this edge
            if (n_defer_valid && (n_defer_addr == r_col)) begin
                r_a_byp_hit  <= 1'b1;
                r_a_byp_data <= n_defer_data;
            end else if (wr_en && (wr_addr == r_col)) begin
                r_a_byp_hit  <= 1'b1;
                r_a_byp_data <= wr_data;
            end else begin
                r_a_byp_hit  <= 1'b0;
                r_a_byp_data <= n_defer_data;
            end
        end
        if (a_adv) begin
            r_out_pix <= res.quant;
            r_out_eor <= r_a_last_col;
            r_out_eof <= r_a_last_col && r_a_last_row;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_dithered_pixel = r_out_pix;
    assign o_end_of_row     = r_out_eor;
    assign o_end_of_frame   = r_out_eof;

    // a pending last-column entry is always flushed before the next direct write
    a_defer_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        direct_wr |-> !r_defer_valid)
        else $error("line buffer write collides with pending last-column entry");

    a_eof_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_frame |-> o_end_of_row)
        else $error("end of frame without end of row");

    a_binary_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_dithered_pixel == PIX_MIN) || (o_dithered_pixel == PIX_MAX))
        else $error("dithered word is neither black nor white");

    // the word after an end of row starts a row, so the carried errors are clear
    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_adv && r_a_last_col |=> (r_right == '0) && (r_pend_left == '0))
        else $error("errors carried across a row boundary");

endmodule

`default_nettype wire

### src/fsd_apb_regs.sv
// APB-style configuration registers: image width and image height.
// Depends on fsd_pkg.
`default_nettype none

module fsd_apb_regs
    import fsd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    logic [CFG_W_BITS-1:0] r_width;
    logic [CFG_H_BITS-1:0] r_height;
    logic                  wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (wr_hit) begin
            case (paddr[2])
                REG_IMAGE_WIDTH:  r_width  <= pwdata[CFG_W_BITS-1:0];
                REG_IMAGE_HEIGHT: r_height <= pwdata[CFG_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = {{(32-CFG_W_BITS){1'b0}}, r_width};
            REG_IMAGE_HEIGHT: prdata = {{(32-CFG_H_BITS){1'b0}}, r_height};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.image_width  = r_width;
    assign o_cfg.image_height = r_height;

endmodule

`default_nettype wire

### src/fsd_line_buf.sv
// Next-row error line buffer: one write port, one registered read port.
// Depends on fsd_pkg for the error type.
`default_nettype none

module fsd_line_buf
    import fsd_pkg::*;
#(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire t_err              i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output t_err                   o_rd_data
);

    t_err r_mem [DEPTH];
    t_err r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### src/fsd_diffuse.sv
// Per-pixel arithmetic: error sum, clamp, threshold and the 7/3/5/1 split.
// Depends on fsd_pkg (error type, div16, result struct).
`default_nettype none

module fsd_diffuse
    import fsd_pkg::*;
(
    input  wire logic [7:0] i_pix,
    input  wire t_err       i_below,
    input  wire t_err       i_right,
    input  wire t_err       i_pend_left,
    input  wire t_err       i_pend_center,
    input  wire logic       i_last_col,
    output t_diff_out       o_res
);

    logic signed [9:0]  sum;
    logic [7:0]         clamped;
    logic [7:0]         quant;
    t_err               err;
    logic signed [10:0] err_x;
    t_err               d7, d3, d5, d1;

    always_comb begin
        sum = $signed({2'b00, i_pix}) + 10'(i_below) + 10'(i_right);
        if (sum < 10'sd0) begin
            clamped = PIX_MIN;
        end else if (sum > $signed({2'b00, PIX_MAX})) begin
            clamped = PIX_MAX;
        end else begin
            clamped = sum[7:0];
        end
        quant = (clamped < THRESHOLD) ? PIX_MIN : PIX_MAX;
        err   = t_err'($signed({1'b0, clamped}) - $signed({1'b0, quant}));
        err_x = 11'(err);
        d7    = div16(err_x * WGT_RIGHT);
        d3    = div16(err_x * WGT_BL);
        d5    = div16(err_x * WGT_BELOW);
        d1    = div16(err_x);

        o_res.quant       = quant;
        o_res.left_wr     = i_pend_left + d3;
        o_res.pend_left   = i_pend_center + d5;
        o_res.pend_center = d1;
        o_res.right       = i_last_col ? t_err'(0) : d7;
    end

endmodule

`default_nettype wire
